### hdl/spcc_pkg.sv
// Shared types, constants and the byte-wise CRC-16/CCITT-FALSE update
// for the space packet CRC checker. No dependencies.

package spcc_pkg;

  localparam logic [15:0] CrcPoly   = 16'h1021;
  localparam logic [15:0] CrcInit   = 16'hFFFF;
  localparam logic [15:0] CrcTop    = 16'h8000;
  localparam logic [10:0] ApidMask  = 11'h7FF;
  localparam logic [13:0] CountMask = 14'h3FFF;

  localparam int unsigned HdrBytes  = 6;
  localparam int unsigned TimeEnd   = 12;

  // one buffered input transfer
  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       packet_start;
  } item_t;

  // fields of one decoded packet
  typedef struct packed {
    logic [10:0] apid;
    logic [1:0]  seq_flags;
    logic [13:0] seq_num;
    logic [16:0] user_data_len;
    logic [31:0] time_sec;
    logic [15:0] time_subsec;
    logic [15:0] received_crc;
    logic [15:0] computed_crc;
    logic        crc_ok;
  } result_t;

  // MSB-first CRC update over one byte, no reflection
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CrcTop) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### hdl/space_packet_crc_checker.sv
// Top level of the space packet CRC checker: input register, parser and
// result register. Depends on spcc_pkg, spcc_in_stage and spcc_parser.
//
// Usage:
//   Input channel: one packet byte per transfer (data_byte_i), with
//   packet_start_i high on the first byte of a packet. A start mark in the
//   middle of a packet drops the partial packet. Without a start mark the
//   byte after a packet's last byte opens the next packet.
//   Output channel: one transfer per packet of PACKET_BYTES bytes, carrying
//   the header fields, both CRCs and crc_ok.
//   Throughput: one byte per cycle while in_stall_o is low; the byte CRC
//   update is combinational. A packet's last byte passes through the input
//   register; the parser then forms the result and loads the result
//   register once that register is free.
//   Stall: while out_stall_i holds a result, bytes that end no packet keep
//   flowing; the next packet's last byte waits in the input register and
//   in_stall_o rises.
//   Reset: position 0, CRC 0xFFFF, header captures cleared, both registers
//   empty.

module space_packet_crc_checker #(
  parameter int unsigned PACKET_BYTES = 30
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        packet_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [10:0] apid_o,
  output logic [1:0]  seq_flags_o,
  output logic [13:0] seq_num_o,
  output logic [16:0] user_data_len_o,
  output logic [31:0] time_sec_o,
  output logic [15:0] time_subsec_o,
  output logic [15:0] received_crc_o,
  output logic [15:0] computed_crc_o,
  output logic        crc_ok_o
);

  spcc_pkg::item_t   item;
  spcc_pkg::result_t res, res_q;
  logic              take;
  logic              res_load;
  logic              out_free;
  logic              out_valid_q, out_valid_d;

  spcc_in_stage u_in_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .packet_start_i (packet_start_i),
    .take_i         (take),
    .item_o         (item)
  );

  spcc_parser #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item),
    .out_free_i (out_free),
    .take_o     (take),
    .res_load_o (res_load),
    .res_o      (res)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign apid_o          = res_q.apid;
  assign seq_flags_o     = res_q.seq_flags;
  assign seq_num_o       = res_q.seq_num;
  assign user_data_len_o = res_q.user_data_len;
  assign time_sec_o      = res_q.time_sec;
  assign time_subsec_o   = res_q.time_subsec;
  assign received_crc_o  = res_q.received_crc;
  assign computed_crc_o  = res_q.computed_crc;
  assign crc_ok_o        = res_q.crc_ok;

  // a stalled input always has a held byte behind it
  a_stall_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> item.valid)
    else $error("input stall without a held byte");

  // a new result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !res_load)
    else $error("result overwritten while stalled");

  // match flag agrees with the two CRCs carried alongside it
  a_crc_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (crc_ok_o == (computed_crc_o == received_crc_o)))
    else $error("crc_ok disagrees with CRC fields");

  // the length field plus one can never be zero
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (user_data_len_o != 17'd0))
    else $error("user data length is zero");

endmodule

### hdl/spcc_in_stage.sv
// Input register of the space packet CRC checker: holds one byte transfer
// until the parser takes it. Depends on spcc_pkg.

module spcc_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          data_byte_i,
  input  logic                packet_start_i,
  input  logic                take_i,
  output spcc_pkg::item_t     item_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       start_q;
  logic       load;

  // stall only while a held byte cannot move on this cycle
  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q  <= data_byte_i;
      start_q <= packet_start_i;
    end
  end

  assign item_o.valid        = valid_q;
  assign item_o.data_byte    = byte_q;
  assign item_o.packet_start = start_q;

endmodule

### hdl/spcc_parser.sv
// Packet parser of the space packet CRC checker: byte position, running
// CRC and header capture; forms the result on the last byte. Depends on spcc_pkg.

module spcc_parser #(
  parameter int unsigned PACKET_BYTES = 30
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spcc_pkg::item_t     item_i,
  input  logic                out_free_i,
  output logic                take_o,
  output logic                res_load_o,
  output spcc_pkg::result_t   res_o
);

  localparam int unsigned PosW = $clog2(PACKET_BYTES);
  localparam logic [PosW-1:0] LastPos = PosW'(PACKET_BYTES - 1);
  localparam logic [PosW-1:0] CrcHiPos = PosW'(PACKET_BYTES - 2);
  localparam logic [PosW-1:0] HdrEnd = PosW'(spcc_pkg::HdrBytes);
  localparam logic [PosW-1:0] TimeEnd = PosW'(spcc_pkg::TimeEnd);

  logic [PosW-1:0] pos_q, pos_d, pos_eff;
  logic [15:0]     crc_q, crc_d, crc_eff;
  logic [47:0]     hdr_q, hdr_d;
  logic [47:0]     time_q, time_d;
  logic [7:0]      cap_q, cap_d;
  logic            is_last;
  logic [15:0]     rx_crc;

  // a start mark restarts position and CRC before this byte counts
  assign pos_eff = item_i.packet_start ? '0 : pos_q;
  assign crc_eff = item_i.packet_start ? spcc_pkg::CrcInit : crc_q;
  assign is_last = (pos_eff == LastPos);

  // bytes that end no packet never wait on the output side
  assign take_o     = item_i.valid && (!is_last || out_free_i);
  assign res_load_o = take_o && is_last;

  always_comb begin
    pos_d  = pos_q;
    crc_d  = crc_q;
    hdr_d  = hdr_q;
    time_d = time_q;
    cap_d  = cap_q;
    if (take_o) begin
      if (pos_eff < HdrEnd) begin
        hdr_d = {hdr_q[39:0], item_i.data_byte};
      end else if (pos_eff < TimeEnd) begin
        time_d = {time_q[39:0], item_i.data_byte};
      end
      if (pos_eff < CrcHiPos) begin
        crc_d = spcc_pkg::crc_byte(crc_eff, item_i.data_byte);
        pos_d = pos_eff + 1'b1;
      end else if (pos_eff == CrcHiPos) begin
        cap_d = item_i.data_byte;
        crc_d = crc_eff;
        pos_d = pos_eff + 1'b1;
      end else begin
        crc_d = spcc_pkg::CrcInit;
        pos_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      crc_q  <= spcc_pkg::CrcInit;
      hdr_q  <= '0;
      time_q <= '0;
      cap_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      crc_q  <= crc_d;
      hdr_q  <= hdr_d;
      time_q <= time_d;
      cap_q  <= cap_d;
    end
  end

  assign rx_crc = {cap_q, item_i.data_byte};

  assign res_o.apid          = hdr_q[42:32] & spcc_pkg::ApidMask;
  assign res_o.seq_flags     = hdr_q[31:30];
  assign res_o.seq_num       = hdr_q[29:16] & spcc_pkg::CountMask;
  assign res_o.user_data_len = {1'b0, hdr_q[15:0]} + 17'd1;
  assign res_o.time_sec      = time_q[47:16];
  assign res_o.time_subsec   = time_q[15:0];
  assign res_o.received_crc  = rx_crc;
  assign res_o.computed_crc  = crc_eff;
  assign res_o.crc_ok        = (crc_eff == rx_crc);

endmodule
